FILE: sv/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared codes and types of the selective-repeat sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

  // command field of an input item
  localparam logic [1:0] CMD_SEND    = 2'd0;
  localparam logic [1:0] CMD_ACK     = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  // result status codes
  localparam logic [2:0] STAT_SENT    = 3'd0;
  localparam logic [2:0] STAT_FULL    = 3'd1;
  localparam logic [2:0] STAT_ACK     = 3'd2;
  localparam logic [2:0] STAT_OUTSIDE = 3'd3;
  localparam logic [2:0] STAT_BADCK   = 3'd4;
  localparam logic [2:0] STAT_RESENT  = 3'd5;

  // configuration register indexes
  localparam logic CFG_WINDOW_SIZE = 1'b0;
  localparam logic CFG_SEQ_BITS    = 1'b1;

  localparam logic [7:0] WINDOW_SIZE_RST = 8'd4;
  localparam logic [3:0] SEQ_BITS_RST    = 4'd8;

  // operation decided by the front end
  typedef enum logic [2:0] {
    OP_SEND,
    OP_ACK,
    OP_BADCK,
    OP_TIMEOUT,
    OP_NOP
  } op_e;

  // head of the queue as seen by the back end
  typedef struct packed {
    logic valid;
    op_e  op;
  } head_t;

endpackage

FILE: sv/selective_repeat_sender_window_unit.sv
// Send, bad checksum, out-of-window and unknown items give their result from S_IDLE;
// a timeout passes through S_TMO; an ack in the window through S_ACK, S_SLIDE_RD
// and S_SLIDE, one flag read and one step per acked entry the base slides past.
// New items wait in a two-entry queue while the back end is out of S_IDLE.
// Reset: base and next number zero, window_size 4, seq_bits 8; stores uncleared.
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_unit
// Sender window of a selective-repeat ARQ link: sends, acks and timeouts.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window_unit #(
  parameter int SEQ_BITS_MAX  = 8,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [7:0]               cfg_data_i,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [1:0]               cmd_i,
  input  logic [SEQ_BITS_MAX-1:0]  seq_i,
  input  logic                     checksum_ok_i,
  input  logic [PAYLOAD_WIDTH-1:0] payload_i,
  output logic                     valid_o,
  output logic [2:0]               status_o,
  output logic                     tx_valid_o,
  output logic [SEQ_BITS_MAX-1:0]  tx_seq_o,
  output logic [PAYLOAD_WIDTH-1:0] tx_payload_o,
  output logic                     timer_start_o,
  output logic                     timer_stop_o,
  output logic [SEQ_BITS_MAX-1:0]  timer_seq_o,
  output logic [SEQ_BITS_MAX-1:0]  window_base_o,
  output logic [SEQ_BITS_MAX-1:0]  next_number_o
);
  import srsw_pkg::*;

  head_t                    head;
  logic [SEQ_BITS_MAX-1:0]  head_seq;
  logic [PAYLOAD_WIDTH-1:0] head_payload;
  logic [SEQ_BITS_MAX-1:0]  mask;
  logic                     pop;

  srsw_front #(
    .SEQ_BITS_MAX  (SEQ_BITS_MAX),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .seq_i          (seq_i),
    .checksum_ok_i  (checksum_ok_i),
    .payload_i      (payload_i),
    .mask_i         (mask),
    .pop_i          (pop),
    .head_o         (head),
    .head_seq_o     (head_seq),
    .head_payload_o (head_payload)
  );

  srsw_back #(
    .SEQ_BITS_MAX  (SEQ_BITS_MAX),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .mask_o         (mask),
    .head_i         (head),
    .head_seq_i     (head_seq),
    .head_payload_i (head_payload),
    .pop_o          (pop),
    .valid_o        (valid_o),
    .status_o       (status_o),
    .tx_valid_o     (tx_valid_o),
    .tx_seq_o       (tx_seq_o),
    .tx_payload_o   (tx_payload_o),
    .timer_start_o  (timer_start_o),
    .timer_stop_o   (timer_stop_o),
    .timer_seq_o    (timer_seq_o),
    .window_base_o  (window_base_o),
    .next_number_o  (next_number_o)
  );

endmodule

FILE: sv/srsw_ram.sv
// ----------------------------------------------------------------------------
// srsw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srsw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/srsw_front.sv
// ----------------------------------------------------------------------------
// srsw_front
// Accepts items, decodes the command and queues them for the back end.
// ----------------------------------------------------------------------------
module srsw_front #(
  parameter int SEQ_BITS_MAX  = 8,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [1:0]               cmd_i,
  input  logic [SEQ_BITS_MAX-1:0]  seq_i,
  input  logic                     checksum_ok_i,
  input  logic [PAYLOAD_WIDTH-1:0] payload_i,
  input  logic [SEQ_BITS_MAX-1:0]  mask_i,
  input  logic                     pop_i,
  output srsw_pkg::head_t          head_o,
  output logic [SEQ_BITS_MAX-1:0]  head_seq_o,
  output logic [PAYLOAD_WIDTH-1:0] head_payload_o
);
  import srsw_pkg::*;

  op_e                      op_q  [2];
  logic [SEQ_BITS_MAX-1:0]  seq_q [2];
  logic [PAYLOAD_WIDTH-1:0] pay_q [2];
  logic                     wr_ptr_q, rd_ptr_q;
  logic [1:0]               cnt_q, cnt_d;
  logic                     push;
  op_e                      op_in;

  assign busy_o = (cnt_q == 2'd2);
  assign push   = start_i & ~busy_o;

  always_comb begin
    case (cmd_i)
      CMD_SEND:    op_in = OP_SEND;
      CMD_ACK:     op_in = checksum_ok_i ? OP_ACK : OP_BADCK;
      CMD_TIMEOUT: op_in = OP_TIMEOUT;
      default:     op_in = OP_NOP;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wr_ptr_q]  <= op_in;
      seq_q[wr_ptr_q] <= seq_i & mask_i;
      pay_q[wr_ptr_q] <= payload_i;
    end
  end

  assign head_o.valid   = (cnt_q != 2'd0);
  assign head_o.op      = op_q[rd_ptr_q];
  assign head_seq_o     = seq_q[rd_ptr_q];
  assign head_payload_o = pay_q[rd_ptr_q];

endmodule

FILE: sv/srsw_back.sv
// ----------------------------------------------------------------------------
// srsw_back
// Carries out queued items against the window state and payload store.
// ----------------------------------------------------------------------------
module srsw_back #(
  parameter int SEQ_BITS_MAX  = 8,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [7:0]               cfg_data_i,
  output logic [SEQ_BITS_MAX-1:0]  mask_o,
  input  srsw_pkg::head_t          head_i,
  input  logic [SEQ_BITS_MAX-1:0]  head_seq_i,
  input  logic [PAYLOAD_WIDTH-1:0] head_payload_i,
  output logic                     pop_o,
  output logic                     valid_o,
  output logic [2:0]               status_o,
  output logic                     tx_valid_o,
  output logic [SEQ_BITS_MAX-1:0]  tx_seq_o,
  output logic [PAYLOAD_WIDTH-1:0] tx_payload_o,
  output logic                     timer_start_o,
  output logic                     timer_stop_o,
  output logic [SEQ_BITS_MAX-1:0]  timer_seq_o,
  output logic [SEQ_BITS_MAX-1:0]  window_base_o,
  output logic [SEQ_BITS_MAX-1:0]  next_number_o
);
  import srsw_pkg::*;

  localparam int SB    = SEQ_BITS_MAX;
  localparam int CW    = (SB > 8) ? SB : 8;
  localparam int DEPTH = 1 << SB;

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_ACK        = 3'd1;
  localparam logic [2:0] S_SLIDE_RD   = 3'd2;
  localparam logic [2:0] S_SLIDE      = 3'd3;
  localparam logic [2:0] S_TMO        = 3'd4;

  function automatic logic [SB-1:0] mask_of(input logic [3:0] bits);
    int            eff;
    logic [SB-1:0] m;
    eff = (bits == 4'd0 || int'(bits) > SB) ? SB : int'(bits);
    for (int i = 0; i < SB; i++) begin
      m[i] = (i < eff);
    end
    return m;
  endfunction

  function automatic logic in_window(input logic [SB-1:0] b, input logic [SB-1:0] nx,
                                     input logic [SB-1:0] n);
    logic r;
    if (b == nx) begin
      r = 1'b0;
    end else if (b < nx) begin
      r = (b <= n) && (n < nx);
    end else begin
      r = (n < nx) || (n >= b);
    end
    return r;
  endfunction

  logic [2:0]    state_q, state_d;
  logic [7:0]    ws_q;
  logic [SB-1:0] mask_q;
  logic [SB-1:0] base_q, base_d, next_q, next_d;
  logic [SB-1:0] n_q, n_d;
  logic          stop_q, stop_d;

  // registered result
  logic                     out_valid_q, out_valid_d;
  logic [2:0]               status_q, status_d;
  logic                     txv_q, txv_d;
  logic [SB-1:0]            txs_q, txs_d;
  logic [PAYLOAD_WIDTH-1:0] txp_q, txp_d;
  logic                     tstart_q, tstart_d;
  logic                     tstop_q, tstop_d;
  logic [SB-1:0]            tseq_q, tseq_d;
  logic [SB-1:0]            wb_q, wb_d, nn_q, nn_d;

  // store ports
  logic                     pay_we;
  logic [PAYLOAD_WIDTH-1:0] pay_rdata;
  logic                     ack_we, ack_wdata;
  logic [SB-1:0]            ack_waddr, ack_raddr;
  logic                     ack_rdata;

  logic [SB-1:0] count, next_inc, base_inc;
  logic [CW-1:0] limit;
  logic          full, head_in_win;

  assign count       = (next_q - base_q) & mask_q;
  assign next_inc    = (next_q + SB'(1)) & mask_q;
  assign base_inc    = (base_q + SB'(1)) & mask_q;
  assign limit       = (CW'(ws_q) < CW'(mask_q)) ? CW'(ws_q) : CW'(mask_q);
  assign full        = (CW'(count) >= limit);
  assign head_in_win = in_window(base_q, next_q, head_seq_i);

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    next_d      = next_q;
    n_d         = n_q;
    stop_d      = stop_q;
    pop_o       = 1'b0;
    pay_we      = 1'b0;
    ack_we      = 1'b0;
    ack_wdata   = 1'b0;
    ack_waddr   = next_q;
    ack_raddr   = head_seq_i;
    out_valid_d = 1'b0;
    status_d    = STAT_OUTSIDE;
    txv_d       = 1'b0;
    txs_d       = '0;
    txp_d       = '0;
    tstart_d    = 1'b0;
    tstop_d     = 1'b0;
    tseq_d      = '0;
    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          n_d   = head_seq_i;
          case (head_i.op)
            OP_SEND: begin
              out_valid_d = 1'b1;
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                pay_we    = 1'b1;
                ack_we    = 1'b1;
                status_d  = STAT_SENT;
                txv_d     = 1'b1;
                txs_d     = next_q;
                txp_d     = head_payload_i;
                tstart_d  = 1'b1;
                tseq_d    = next_q;
                next_d    = next_inc;
              end
            end
            OP_BADCK: begin
              out_valid_d = 1'b1;
              status_d    = STAT_BADCK;
            end
            OP_ACK: begin
              if (head_in_win) begin
                state_d = S_ACK;
              end else begin
                out_valid_d = 1'b1;
              end
            end
            OP_TIMEOUT: begin
              if (head_in_win) begin
                state_d = S_TMO;
              end else begin
                out_valid_d = 1'b1;
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_ACK: begin
        // duplicate acks leave the flag and the timer alone
        stop_d = ~ack_rdata;
        if (!ack_rdata) begin
          ack_we    = 1'b1;
          ack_wdata = 1'b1;
          ack_waddr = n_q;
        end
        state_d = S_SLIDE_RD;
      end
      S_SLIDE_RD: begin
        ack_raddr = base_q;
        state_d   = S_SLIDE;
      end
      S_SLIDE: begin
        // one acked entry per cycle, next flag read in flight
        ack_raddr = base_inc;
        if (base_q != next_q && ack_rdata) begin
          base_d = base_inc;
        end else begin
          out_valid_d = 1'b1;
          status_d    = STAT_ACK;
          tstop_d     = stop_q;
          tseq_d      = stop_q ? n_q : '0;
          state_d     = S_IDLE;
        end
      end
      S_TMO: begin
        out_valid_d = 1'b1;
        if (!ack_rdata) begin
          status_d = STAT_RESENT;
          txv_d    = 1'b1;
          txs_d    = n_q;
          txp_d    = pay_rdata;
          tstart_d = 1'b1;
          tseq_d   = n_q;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    wb_d = base_d;
    nn_d = next_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ws_q        <= WINDOW_SIZE_RST;
      mask_q      <= mask_of(SEQ_BITS_RST);
      base_q      <= '0;
      next_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && cfg_idx_i == CFG_SEQ_BITS) begin
        mask_q <= mask_of(cfg_data_i[3:0]);
        base_q <= '0;
        next_q <= '0;
      end else begin
        base_q <= base_d;
        next_q <= next_d;
      end
      if (cfg_we_i && cfg_idx_i == CFG_WINDOW_SIZE) begin
        ws_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    stop_q   <= stop_d;
    status_q <= status_d;
    txv_q    <= txv_d;
    txs_q    <= txs_d;
    txp_q    <= txp_d;
    tstart_q <= tstart_d;
    tstop_q  <= tstop_d;
    tseq_q   <= tseq_d;
    wb_q     <= wb_d;
    nn_q     <= nn_d;
  end

  srsw_ram #(
    .WIDTH (PAYLOAD_WIDTH),
    .DEPTH (DEPTH)
  ) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (next_q),
    .wdata_i (head_payload_i),
    .raddr_i (head_seq_i),
    .rdata_o (pay_rdata)
  );

  srsw_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_ack_ram (
    .clk_i   (clk_i),
    .we_i    (ack_we),
    .waddr_i (ack_waddr),
    .wdata_i (ack_wdata),
    .raddr_i (ack_raddr),
    .rdata_o (ack_rdata)
  );

  assign mask_o        = mask_q;
  assign valid_o       = out_valid_q;
  assign status_o      = status_q;
  assign tx_valid_o    = txv_q;
  assign tx_seq_o      = txs_q;
  assign tx_payload_o  = txp_q;
  assign timer_start_o = tstart_q;
  assign timer_stop_o  = tstop_q;
  assign timer_seq_o   = tseq_q;
  assign window_base_o = wb_q;
  assign next_number_o = nn_q;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the selective-repeat sender window: sends, acks and timeouts are
// driven through the start/busy port and every strobed result is compared
// field by field with a cycle-free model of the window kept in this bench.
// ----------------------------------------------------------------------------
module tb;
  import srsw_pkg::*;

  localparam int SEQ_W = 8;
  localparam int PAY_W = 32;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [2:0]       status;
    logic             tx_valid;
    logic [SEQ_W-1:0] tx_seq;
    logic [PAY_W-1:0] tx_payload;
    logic             timer_start;
    logic             timer_stop;
    logic [SEQ_W-1:0] timer_seq;
    logic [SEQ_W-1:0] window_base;
    logic [SEQ_W-1:0] next_number;
  } window_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_idx_i = 1'b0;
  logic [7:0]       cfg_data_i = '0;
  logic             start_i = 1'b0;
  logic             busy_o;
  logic [1:0]       cmd_i = '0;
  logic [SEQ_W-1:0] seq_i = '0;
  logic             checksum_ok_i = 1'b0;
  logic [PAY_W-1:0] payload_i = '0;
  logic             valid_o;
  logic [2:0]       status_o;
  logic             tx_valid_o;
  logic [SEQ_W-1:0] tx_seq_o;
  logic [PAY_W-1:0] tx_payload_o;
  logic             timer_start_o;
  logic             timer_stop_o;
  logic [SEQ_W-1:0] timer_seq_o;
  logic [SEQ_W-1:0] window_base_o;
  logic [SEQ_W-1:0] next_number_o;

  selective_repeat_sender_window_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .cmd_i         (cmd_i),
    .seq_i         (seq_i),
    .checksum_ok_i (checksum_ok_i),
    .payload_i     (payload_i),
    .valid_o       (valid_o),
    .status_o      (status_o),
    .tx_valid_o    (tx_valid_o),
    .tx_seq_o      (tx_seq_o),
    .tx_payload_o  (tx_payload_o),
    .timer_start_o (timer_start_o),
    .timer_stop_o  (timer_stop_o),
    .timer_seq_o   (timer_seq_o),
    .window_base_o (window_base_o),
    .next_number_o (next_number_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // window model
  logic [7:0]       win_size = WINDOW_SIZE_RST;
  logic [3:0]       win_seq_bits = SEQ_BITS_RST;
  int               win_base = 0;
  int               win_next = 0;
  bit               win_acked [256];
  logic [PAY_W-1:0] win_store [256];

  window_result_t pending_results [$];
  int mismatch_count = 0;
  int items_accepted = 0;
  int reg_writes = 0;
  int status_seen [6];
  int burst_left = 0;

  function automatic int seq_modulus();
    if (win_seq_bits == 4'd0 || win_seq_bits > SEQ_W)
      return 1 << SEQ_W;
    return 1 << win_seq_bits;
  endfunction

  function automatic bit in_flight(int n);
    if (win_base == win_next)
      return 1'b0;
    if (win_base < win_next)
      return win_base <= n && n < win_next;
    return n < win_next || n >= win_base;
  endfunction

  function automatic window_result_t predict_window_step(logic [1:0] cmd,
      logic [SEQ_W-1:0] seq, logic ck, logic [PAY_W-1:0] pay);
    window_result_t r;
    int m;
    int n;
    int count;
    int limit;
    m = seq_modulus();
    n = int'(seq) & (m - 1);
    r = '0;
    r.status = STAT_OUTSIDE;
    case (cmd)
      CMD_SEND: begin
        count = (win_next - win_base) & (m - 1);
        limit = (int'(win_size) < m - 1) ? int'(win_size) : m - 1;
        if (count >= limit) begin
          r.status = STAT_FULL;
        end else begin
          win_store[win_next] = pay;
          win_acked[win_next] = 1'b0;
          r.status = STAT_SENT;
          r.tx_valid = 1'b1;
          r.tx_seq = win_next[SEQ_W-1:0];
          r.tx_payload = pay;
          r.timer_start = 1'b1;
          r.timer_seq = win_next[SEQ_W-1:0];
          win_next = (win_next + 1) & (m - 1);
        end
      end
      CMD_ACK: begin
        if (!ck) begin
          r.status = STAT_BADCK;
        end else if (in_flight(n)) begin
          r.status = STAT_ACK;
          if (!win_acked[n]) begin
            win_acked[n] = 1'b1;
            r.timer_stop = 1'b1;
            r.timer_seq = n[SEQ_W-1:0];
          end
          while (win_base != win_next && win_acked[win_base])
            win_base = (win_base + 1) & (m - 1);
        end
      end
      CMD_TIMEOUT: begin
        if (in_flight(n) && !win_acked[n]) begin
          r.status = STAT_RESENT;
          r.tx_valid = 1'b1;
          r.tx_seq = n[SEQ_W-1:0];
          r.tx_payload = win_store[n];
          r.timer_start = 1'b1;
          r.timer_seq = n[SEQ_W-1:0];
        end
      end
      default: ;
    endcase
    r.window_base = win_base[SEQ_W-1:0];
    r.next_number = win_next[SEQ_W-1:0];
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
      input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    window_result_t want;
    if (rst_ni && valid_o) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none expected, expected none, actual status %0h",
                 $time, status_o);
      end else begin
        want = pending_results.pop_front();
        if (want.status <= STAT_RESENT)
          status_seen[want.status]++;
        compare_field("status", 32'(want.status), 32'(status_o));
        compare_field("tx_valid", 32'(want.tx_valid), 32'(tx_valid_o));
        compare_field("tx_seq", 32'(want.tx_seq), 32'(tx_seq_o));
        compare_field("tx_payload", want.tx_payload, tx_payload_o);
        compare_field("timer_start", 32'(want.timer_start), 32'(timer_start_o));
        compare_field("timer_stop", 32'(want.timer_stop), 32'(timer_stop_o));
        compare_field("timer_seq", 32'(want.timer_seq), 32'(timer_seq_o));
        compare_field("window_base", 32'(want.window_base), 32'(window_base_o));
        compare_field("next_number", 32'(want.next_number), 32'(next_number_o));
      end
    end
  end

  // bursts of back-to-back items with random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      burst_left = $urandom_range(1, 40);
      @(negedge clk_i) start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    burst_left--;
  endtask

  task automatic send_item(input logic [1:0] cmd, input logic [SEQ_W-1:0] seq,
      input logic ck, input logic [PAY_W-1:0] pay);
    pace_sender();
    @(negedge clk_i);
    start_i <= 1'b1;
    cmd_i <= cmd;
    seq_i <= seq;
    checksum_ok_i <= ck;
    payload_i <= pay;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(predict_window_step(cmd, seq, ck, pay));
    items_accepted++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i) start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input logic idx, input logic [7:0] data);
    wait_drained();
    repeat (12) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i) cfg_we_i <= 1'b0;
    if (idx == CFG_WINDOW_SIZE) begin
      win_size = data;
    end else begin
      win_seq_bits = data[3:0];
      win_base = 0;
      win_next = 0;
    end
    reg_writes++;
  endtask

  // a number inside the current window (any number when it is empty), with noise above the sequence width
  function automatic logic [SEQ_W-1:0] pick_in_flight();
    int m;
    int count;
    int n;
    m = seq_modulus();
    count = (win_next - win_base) & (m - 1);
    if (count == 0)
      n = $urandom_range(0, m - 1);
    else
      n = (win_base + $urandom_range(0, count - 1)) & (m - 1);
    return SEQ_W'(($urandom_range(0, 255) & ~(m - 1)) | n);
  endfunction

  task automatic test_directed_basics();
    send_item(CMD_SEND, 8'd0, 1'b0, 32'h0000_0000);
    send_item(CMD_SEND, 8'd0, 1'b1, 32'hFFFF_FFFF);
    send_item(CMD_SEND, 8'd77, 1'b0, $urandom);
    send_item(CMD_SEND, 8'd255, 1'b1, $urandom);
    send_item(CMD_SEND, 8'd0, 1'b0, $urandom);        // window full
    send_item(CMD_ACK, 8'd1, 1'b1, 32'h0);
    send_item(CMD_ACK, 8'd1, 1'b1, 32'hFFFF_FFFF);    // duplicate ack
    send_item(CMD_ACK, 8'd2, 1'b0, 32'h0);            // bad checksum
    send_item(CMD_ACK, 8'd200, 1'b1, 32'h0);          // outside window
    send_item(CMD_TIMEOUT, 8'd1, 1'b1, 32'h0);        // stale: already acked
    send_item(CMD_TIMEOUT, 8'd2, 1'b0, 32'h0);        // resend
    send_item(CMD_TIMEOUT, 8'd9, 1'b1, 32'h0);        // stale: outside
    send_item(CMD_ACK, 8'd0, 1'b1, 32'h0);            // base slides over acked
    send_item(CMD_UNKNOWN, 8'd255, 1'b1, 32'hFFFF_FFFF);
    send_item(CMD_ACK, 8'd3, 1'b1, 32'h0);
    send_item(CMD_ACK, 8'd2, 1'b1, 32'h0);            // window empties
    send_item(CMD_TIMEOUT, 8'd0, 1'b0, 32'h0);
    send_item(CMD_ACK, 8'd255, 1'b0, 32'hFFFF_FFFF);
  endtask

  task automatic test_zero_window();
    write_register(CFG_WINDOW_SIZE, 8'd0);
    send_item(CMD_SEND, 8'd0, 1'b1, $urandom);
    send_item(CMD_ACK, 8'd4, 1'b1, 32'h0);
    send_item(CMD_TIMEOUT, 8'd4, 1'b1, 32'h0);
  endtask

  task automatic test_width_change();
    write_register(CFG_WINDOW_SIZE, 8'd255);
    write_register(CFG_SEQ_BITS, 8'd1);
    send_item(CMD_SEND, 8'd0, 1'b1, $urandom);
    send_item(CMD_SEND, 8'd0, 1'b1, $urandom);        // one in flight at width 1
    send_item(CMD_TIMEOUT, 8'hFE, 1'b1, 32'h0);       // upper bits dropped
    send_item(CMD_ACK, 8'hFE, 1'b1, 32'h0);
    send_item(CMD_SEND, 8'd0, 1'b1, $urandom);
    send_item(CMD_SEND, 8'd0, 1'b1, $urandom);
    write_register(CFG_SEQ_BITS, 8'd0);               // acts as full width
    send_item(CMD_SEND, 8'd0, 1'b1, $urandom);
    send_item(CMD_ACK, 8'd1, 1'b1, 32'h0);
    write_register(CFG_SEQ_BITS, 8'hFF);              // width 15 acts as full width
    send_item(CMD_SEND, 8'd0, 1'b1, $urandom);
  endtask

  task automatic random_item(input int send_pct);
    int r;
    if ($urandom_range(0, 199) == 0)
      wait_drained();
    r = $urandom_range(0, 99);
    if (r < send_pct) begin
      send_item(CMD_SEND, SEQ_W'($urandom), 1'($urandom), $urandom);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55)
        send_item(CMD_ACK, pick_in_flight(), 1'b1, $urandom);
      else if (r < 80)
        send_item(CMD_TIMEOUT, pick_in_flight(), 1'($urandom), $urandom);
      else if (r < 87)
        send_item(CMD_ACK, SEQ_W'($urandom), 1'b0, $urandom);
      else if (r < 93)
        send_item(CMD_ACK, SEQ_W'($urandom), 1'b1, $urandom);
      else if (r < 98)
        send_item(CMD_TIMEOUT, SEQ_W'($urandom), 1'($urandom), $urandom);
      else
        send_item(CMD_UNKNOWN, SEQ_W'($urandom), 1'($urandom), $urandom);
    end
  endtask

  task automatic test_random_traffic();
    logic [7:0] phase_size [8] = '{8'd4, 8'd255, 8'd1, 8'd3, 8'd255, 8'd10, 8'd100, 8'd2};
    logic [7:0] phase_bits [8] = '{8'h08, 8'h08, 8'h01, 8'h22, 8'h03, 8'h00, 8'h0C, 8'h04};
    int send_pct;
    for (int p = 0; p < 8; p++) begin
      write_register(CFG_WINDOW_SIZE, phase_size[p]);
      write_register(CFG_SEQ_BITS, phase_bits[p]);
      send_pct = $urandom_range(35, 65);
      repeat (125) random_item(send_pct);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_basics();
    test_zero_window();
    test_width_change();
    test_random_traffic();
    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("covered %0d items across %0d register writes", items_accepted, reg_writes);
    $display("sent %0d, full %0d, acked %0d, outside %0d, bad checksum %0d, resent %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(15_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule
